@@ rtl/ipbp_pkg.sv @@
// Shared types and constants of the indexed pixel bit packer.
package ipbp_pkg;

	// Direction register codes
	typedef enum logic {
		DIR_PACK   = 1'b0,
		DIR_UNPACK = 1'b1
	} dir_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd2;

	// Depth codes; the spare code behaves as 4 bits per pixel
	localparam logic [1:0] DEPTH_1BPP  = 2'd0;
	localparam logic [1:0] DEPTH_2BPP  = 2'd1;
	localparam logic [1:0] DEPTH_4BPP  = 2'd2;
	localparam logic [1:0] DEPTH_SPARE = 2'd3;

	localparam int PIX_W                  = 8;
	localparam int DEFAULT_MAX_LINE_WIDTH = 4096;
	localparam int QUEUE_DEPTH            = 4;

	// One job from the front to the back: a packed byte to send, or a byte to unpack
	typedef struct packed {
		dir_t             kind;
		logic [PIX_W-1:0] data;
		logic [2:0]       cnt_m1;  // beats minus one
		logic             eol;     // final beat closes the line
		logic [1:0]       dc;      // resolved depth code
	} job_t;

endpackage

@@ rtl/ipbp_front.sv @@
// Front end: configuration registers, line tracking, packing and job creation.
module ipbp_front #(
	parameter int MAX_LINE_WIDTH = ipbp_pkg::DEFAULT_MAX_LINE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ipbp_pkg::PIX_W-1:0]      s_tdata,
	input  logic                            q_full,
	output logic                            q_push,
	output ipbp_pkg::job_t                  q_job
);

	localparam int PW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CW = (PW > ipbp_pkg::CFG_DATA_W) ? PW : ipbp_pkg::CFG_DATA_W;

	ipbp_pkg::dir_t                  direction_q;
	logic [1:0]                      depth_code_q;
	logic [ipbp_pkg::CFG_DATA_W-1:0] line_width_q;
	logic [7:0]                      acc_q;
	logic [2:0]                      slot_q;
	logic [PW-1:0]                   pixels_left_q;

	logic [CW-1:0] lw_ext;
	logic [PW-1:0] eff_width;
	logic [1:0]    dc_eff;
	logic [3:0]    per_byte;
	logic [2:0]    shift;
	logic [7:0]    acc_new;
	logic [3:0]    slot_new;
	logic [PW-1:0] pl_dec;
	logic          pack_emit;
	logic          pack_eol;
	logic          unpack_eol;
	logic          accept;

	// Effective line width: zero reads as one, large values saturate
	always_comb begin
		lw_ext = CW'(line_width_q);
		if (lw_ext == '0) begin
			eff_width = PW'(1);
		end else if (lw_ext > CW'(MAX_LINE_WIDTH)) begin
			eff_width = PW'(MAX_LINE_WIDTH);
		end else begin
			eff_width = PW'(lw_ext);
		end
	end

	// Depth code three behaves as four bits per pixel
	assign dc_eff   = (depth_code_q == ipbp_pkg::DEPTH_SPARE) ? ipbp_pkg::DEPTH_4BPP : depth_code_q;
	assign per_byte = 4'd8 >> dc_eff;

	// Slot position of the incoming pixel, first pixel in the top bits
	always_comb begin
		case (dc_eff)
			ipbp_pkg::DEPTH_1BPP: shift = 3'd7 - slot_q;
			ipbp_pkg::DEPTH_2BPP: shift = 3'd6 - {slot_q[1:0], 1'b0};
			default:              shift = slot_q[0] ? 3'd0 : 3'd4;
		endcase
	end

	assign acc_new    = acc_q | 8'(s_tdata << shift);
	assign slot_new   = {1'b0, slot_q} + 4'd1;
	assign pl_dec     = pixels_left_q - PW'(1);
	assign pack_eol   = (pl_dec == '0);
	assign pack_emit  = (slot_new == per_byte) || pack_eol;
	assign unpack_eol = (pixels_left_q <= PW'(per_byte));

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Build the job for the queue
	always_comb begin
		q_job.kind = direction_q;
		q_job.dc   = dc_eff;
		if (direction_q == ipbp_pkg::DIR_PACK) begin
			q_job.data   = acc_new;
			q_job.cnt_m1 = 3'd0;
			q_job.eol    = pack_eol;
			q_push       = accept && pack_emit;
		end else begin
			q_job.data   = s_tdata;
			q_job.cnt_m1 = unpack_eol ? 3'(pl_dec) : 3'(per_byte - 4'd1);
			q_job.eol    = unpack_eol;
			q_push       = accept;
		end
	end

	// Hold configuration and line state; a used-index write restarts the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= ipbp_pkg::DIR_PACK;
			depth_code_q  <= ipbp_pkg::DEPTH_1BPP;
			line_width_q  <= ipbp_pkg::CFG_DATA_W'(1);
			acc_q         <= '0;
			slot_q        <= '0;
			pixels_left_q <= PW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ipbp_pkg::REG_DIRECTION: begin
					direction_q   <= ipbp_pkg::dir_t'(cfg_data[0]);
					acc_q         <= '0;
					slot_q        <= '0;
					pixels_left_q <= eff_width;
				end
				ipbp_pkg::REG_DEPTH_CODE: begin
					depth_code_q  <= cfg_data[1:0];
					acc_q         <= '0;
					slot_q        <= '0;
					pixels_left_q <= eff_width;
				end
				ipbp_pkg::REG_LINE_WIDTH: begin
					line_width_q  <= cfg_data;
					acc_q         <= '0;
					slot_q        <= '0;
					pixels_left_q <= PW'(1);
					if (cfg_data == '0) begin
						pixels_left_q <= PW'(1);
					end else if (CW'(cfg_data) > CW'(MAX_LINE_WIDTH)) begin
						pixels_left_q <= PW'(MAX_LINE_WIDTH);
					end else begin
						pixels_left_q <= PW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (direction_q == ipbp_pkg::DIR_PACK) begin
				if (pack_emit) begin
					acc_q         <= '0;
					slot_q        <= '0;
					pixels_left_q <= pack_eol ? eff_width : pl_dec;
				end else begin
					acc_q         <= acc_new;
					slot_q        <= slot_new[2:0];
					pixels_left_q <= pl_dec;
				end
			end else begin
				pixels_left_q <= unpack_eol ? eff_width : (pixels_left_q - PW'(per_byte));
			end
		end
	end

endmodule

@@ rtl/ipbp_queue.sv @@
// Short job queue between the front and the back.
module ipbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ipbp_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output ipbp_pkg::job_t head
);

	localparam int AW = $clog2(ipbp_pkg::QUEUE_DEPTH);

	ipbp_pkg::job_t mem_q [ipbp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign full       = (count_q == (AW + 1)'(ipbp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

endmodule

@@ rtl/ipbp_back.sv @@
// Back end: expands jobs into the output register, one beat per cycle unless stalled.
module ipbp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  ipbp_pkg::job_t             head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ipbp_pkg::PIX_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	logic [2:0]                 k_q;
	logic                       out_valid_q;
	logic [ipbp_pkg::PIX_W-1:0] out_data_q;
	logic                       out_eol_q;
	logic                       out_last_q;

	logic                       fire;
	logic                       last_beat;
	logic [2:0]                 sh;
	logic [7:0]                 shifted;
	logic [ipbp_pkg::PIX_W-1:0] pixel;
	logic [ipbp_pkg::PIX_W-1:0] beat_data;

	assign fire      = head_valid && (!out_valid_q || m_tready);
	assign last_beat = (k_q == head.cnt_m1);
	assign pop       = fire && last_beat;

	// Pick the field of pixel k, first pixel in the top bits
	assign sh      = 3'(k_q << head.dc);
	assign shifted = head.data << sh;
	always_comb begin
		case (head.dc)
			ipbp_pkg::DEPTH_1BPP: pixel = {7'd0, shifted[7]};
			ipbp_pkg::DEPTH_2BPP: pixel = {6'd0, shifted[7:6]};
			default:              pixel = {4'd0, shifted[7:4]};
		endcase
	end

	assign beat_data = (head.kind == ipbp_pkg::DIR_PACK) ? head.data : pixel;

	// Advance the beat counter within a job and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				k_q <= last_beat ? 3'd0 : (k_q + 3'd1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= beat_data;
			out_last_q <= last_beat;
			out_eol_q  <= last_beat && head.eol;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_eol_q;
	assign m_tuser  = out_last_q;

endmodule

@@ rtl/indexed_pixel_bit_packer.sv @@
// Top level of the indexed pixel bit packer.
// Converts a line of palette indices between one byte per pixel and packed
// 1, 2 or 4 bits per pixel, first pixel in the most significant bits. In pack
// mode one index is taken every cycle while the job queue is not full, and a
// packed byte leaves when it is full or the line ends (unused low bits zero).
// In unpack mode each byte yields up to 8, 4 or 2 pixels, stopping at the line
// end; the back end sends one pixel per cycle while the output is not stalled.
// The front end accepts and classifies beats into a four-entry job queue,
// which lets input keep flowing while the output side stalls. m_tlast marks
// the beat that closes a line, m_tuser the final beat caused by an input beat.
// A direction, depth or width write restarts the line; write only while idle.
module indexed_pixel_bit_packer #(
	parameter int MAX_LINE_WIDTH = ipbp_pkg::DEFAULT_MAX_LINE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] data_out
	output logic                            m_tlast,   // end_of_line
	output logic                            m_tuser    // [0] last_of_run
);

	logic           q_full;
	logic           q_push;
	ipbp_pkg::job_t q_job;
	logic           q_pop;
	logic           q_head_valid;
	ipbp_pkg::job_t q_head;

	ipbp_front #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	ipbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.job_in    (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head      (q_head)
	);

	ipbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_head_valid),
		.head      (q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

@@ rtl/ipbp_checker.sv @@
// Port-level checks of the indexed pixel bit packer, bound to the top level.
module ipbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// A stalled output beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A line always ends on the final beat of an input beat
	a_eol_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("end of line on a beat that is not last of its run");

	// Input only backs up when output holds a pending beat
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

	// A valid output beat carries known data and flags
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
		else $error("output beat with unknown bits");

endmodule

bind indexed_pixel_bit_packer ipbp_checker u_ipbp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

@@ test/ipbp_checker.sv @@
// Beat checker for the indexed pixel bit packer: predicts output beats and compares them.
`timescale 1ns / 1ps

module ipbp_beat_checker #(
	parameter int MAX_LINE_WIDTH = ipbp_pkg::DEFAULT_MAX_LINE_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_in
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [7:0]                      m_tdata,   // [7:0] data_out
	input  logic                            m_tlast,   // end_of_line
	input  logic                            m_tuser,   // [0] last_of_run
	output int                              mismatches,
	output int                              due_count,
	output int                              lines_closed,
	output int                              beats_out
);

	typedef struct packed {
		logic [7:0] data;
		logic       eol;
		logic       run_end;
	} out_beat_t;

	// Beats still owed by the block, oldest first
	out_beat_t due_beats[$];

	// Shadow registers and line state
	ipbp_pkg::dir_t mode;
	logic [1:0]     depth_reg;
	logic [12:0]    width_reg;
	logic [7:0]     acc;
	int             slot;
	int             left;

	function automatic int line_len();
		if (width_reg == 13'd0)
			return 1;
		if (width_reg > MAX_LINE_WIDTH)
			return MAX_LINE_WIDTH;
		return width_reg;
	endfunction

	function automatic int pix_bits();
		case (depth_reg)
			ipbp_pkg::DEPTH_1BPP: return 1;
			ipbp_pkg::DEPTH_2BPP: return 2;
			default:              return 4;
		endcase
	endfunction

	task automatic restart_line();
		acc  = 8'd0;
		slot = 0;
		left = line_len();
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Work out the beats that one accepted input beat causes
	task automatic convert_beat(input logic [7:0] d);
		int         bits;
		int         per;
		int         sh;
		int         k;
		logic [7:0] msk;
		out_beat_t  ob;
		bits = pix_bits();
		per  = 8 / bits;
		msk  = (8'd1 << bits) - 8'd1;
		if (left == 0 || left > line_len())
			left = line_len();
		if (mode == ipbp_pkg::DIR_PACK) begin
			sh   = 8 - bits * (slot + 1);
			acc  = acc | (d << sh);
			slot++;
			left--;
			if (slot >= per || left == 0) begin
				ob.data    = acc;
				ob.run_end = 1'b1;
				ob.eol     = (left == 0);
				due_beats.push_back(ob);
				acc  = 8'd0;
				slot = 0;
				if (ob.eol)
					left = line_len();
			end
		end else begin
			for (k = 0; k < per; k++) begin
				sh = 8 - bits * (k + 1);
				left--;
				ob.data    = (d >> sh) & msk;
				ob.eol     = (left == 0);
				ob.run_end = (k == per - 1) || ob.eol;
				due_beats.push_back(ob);
				if (ob.eol) begin
					left = line_len();
					break;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_beat;
		if (!arst_n) begin
			mode      = ipbp_pkg::DIR_PACK;
			depth_reg = ipbp_pkg::DEPTH_1BPP;
			width_reg = 13'd1;
			restart_line();
			due_beats.delete();
			mismatches   = 0;
			lines_closed = 0;
			beats_out    = 0;
			due_count   <= 0;
		end else begin
			// Track register writes; every known index restarts the line
			if (cfg_we) begin
				case (cfg_index)
					ipbp_pkg::REG_DIRECTION: begin
						mode = ipbp_pkg::dir_t'(cfg_data[0]);
						restart_line();
					end
					ipbp_pkg::REG_DEPTH_CODE: begin
						depth_reg = cfg_data[1:0];
						restart_line();
					end
					ipbp_pkg::REG_LINE_WIDTH: begin
						width_reg = cfg_data;
						restart_line();
					end
					default: ;
				endcase
			end

			if (s_tvalid && s_tready)
				convert_beat(s_tdata);

			// Compare each output beat with the oldest prediction
			if (m_tvalid && m_tready) begin
				beats_out++;
				if (due_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat data=%02h last=%0b user=%0b",
						m_tdata, m_tlast, m_tuser));
				end else begin
					exp_beat = due_beats.pop_front();
					if (m_tdata !== exp_beat.data)
						report_mismatch($sformatf("data %02h, want %02h", m_tdata, exp_beat.data));
					if (m_tlast !== exp_beat.eol)
						report_mismatch($sformatf("end of line %0b, want %0b",
							m_tlast, exp_beat.eol));
					if (m_tuser !== exp_beat.run_end)
						report_mismatch($sformatf("last of run %0b, want %0b",
							m_tuser, exp_beat.run_end));
					if (exp_beat.eol)
						lines_closed++;
				end
			end
			due_count <= due_beats.size();
		end
	end

endmodule

@@ test/tb_indexed_pixel_bit_packer.sv @@
// Testbench top for the indexed pixel bit packer: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_indexed_pixel_bit_packer;

	localparam logic [ipbp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_HOLD     = 24;
	localparam int RANDOM_ITEMS   = 200;
	localparam int QUIET_TAIL     = 30;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [ipbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ipbp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata   = 8'd0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [7:0]                      m_tdata;
	logic                            m_tlast;
	logic                            m_tuser;

	int mismatches;
	int due_count;
	int lines_closed;
	int beats_out;
	int items_sent  = 0;
	int settings    = 0;
	int stall_left  = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;

	always #4 clk = ~clk;

	indexed_pixel_bit_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	ipbp_beat_checker u_beat_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.due_count   (due_count),
		.lines_closed(lines_closed),
		.beats_out   (beats_out)
	);

	// Receiver: stall in random bursts, none while calm
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: end the run after too long without any beat or write
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one input beat, possibly after a short gap, and wait for acceptance
	task automatic send_pixel(input logic [7:0] d);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Hold input until every predicted beat is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
	endtask

	// Drain, then let a partial pack byte settle before touching registers
	task automatic settle();
		wait_drained();
		repeat (DRAIN_HOLD) @(posedge clk);
	endtask

	// Write all registers, junk in the unused bits, plus the spare index
	task automatic load_mode(input ipbp_pkg::dir_t dir, input logic [1:0] dc,
		input logic [12:0] width);
		logic [12:0] junk;
		junk      = 13'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= ipbp_pkg::REG_DIRECTION;
		cfg_data  <= {junk[12:1], dir};
		@(posedge clk);
		junk      = 13'($urandom);
		cfg_index <= ipbp_pkg::REG_DEPTH_CODE;
		cfg_data  <= {junk[12:2], dc};
		@(posedge clk);
		cfg_index <= ipbp_pkg::REG_LINE_WIDTH;
		cfg_data  <= width;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= 13'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		logic [7:0]     pack_run [0:8];
		logic [7:0]     nibble_run [0:2];
		int             target;
		int             n;
		int             k;
		bit             paused;
		ipbp_pkg::dir_t dir;
		logic [1:0]     dc;
		logic [12:0]    w;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pack at 1 bpp, line of 9: spilling index bits, then a partial final byte
		pack_run = '{8'hFF, 8'h01, 8'h00, 8'h01, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h01};
		load_mode(ipbp_pkg::DIR_PACK, ipbp_pkg::DEPTH_1BPP, 13'd9);
		foreach (pack_run[i])
			send_pixel(pack_run[i]);

		// Unpack at 2 bpp, line of 6: line ends inside the second byte
		settle();
		load_mode(ipbp_pkg::DIR_UNPACK, ipbp_pkg::DEPTH_2BPP, 13'd6);
		send_pixel(8'hE4);
		send_pixel(8'h1B);
		send_pixel(8'hFF);

		// Depth code three and zero width: one 4-bit pixel per byte
		settle();
		load_mode(ipbp_pkg::DIR_UNPACK, ipbp_pkg::DEPTH_SPARE, 13'd0);
		send_pixel(8'hA5);
		send_pixel(8'h00);

		// Pack at 4 bpp with an oversized width; the open byte is dropped by the next write
		nibble_run = '{8'hFF, 8'h0F, 8'hF0};
		settle();
		load_mode(ipbp_pkg::DIR_PACK, ipbp_pkg::DEPTH_4BPP, 13'h1FFF);
		foreach (nibble_run[i])
			send_pixel(nibble_run[i]);

		// Unpack at 1 bpp on the widest line
		settle();
		load_mode(ipbp_pkg::DIR_UNPACK, ipbp_pkg::DEPTH_1BPP, 13'd4096);
		send_pixel(8'h80);
		send_pixel(8'h01);

		// Random settings and lines, mostly short widths
		target = items_sent + RANDOM_ITEMS;
		paused = 1'b0;
		while (items_sent < target) begin
			settle();
			dir = ipbp_pkg::dir_t'($urandom_range(0, 1));
			dc  = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 11))
				0:       w = 13'd0;
				1:       w = 13'h1FFF;
				2:       w = 13'd4096;
				3:       w = 13'd1;
				default: w = 13'($urandom_range(2, 40));
			endcase
			calm = (target - items_sent <= QUIET_TAIL) || ($urandom_range(0, 4) == 0);
			load_mode(dir, dc, w);
			n = $urandom_range(6, 40);
			for (k = 0; k < n && items_sent < target; k++) begin
				// Once, stop mid-line until the block has caught up
				if (!paused && k == n / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				send_pixel(8'($urandom));
				if (target - items_sent <= QUIET_TAIL)
					calm = 1'b1;
			end
		end
		settle();

		$display("Sent %0d input beats over %0d register settings,", items_sent, settings);
		$display("both directions and all depths; checked %0d output beats, %0d closing a line.",
			beats_out, lines_closed);
		if (mismatches == 0 && due_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
